[rtl/core/lfpoc_pkg.sv]
// Shared types, codes and helpers for the stack / queue / priority order checker.
package lfpoc_pkg;

    // Default sizing
    localparam int DEF_STORE_DEPTH = 256;
    localparam int DEF_VALUE_BITS  = 32;

    // Result word: verdict, three candidate flags, overflow, one pad bit
    localparam int RES_BITS = 8;
    localparam int CMD_BITS = 2;

    // Candidate flag positions
    localparam int FLAG_STACK = 0;
    localparam int FLAG_QUEUE = 1;
    localparam int FLAG_PRIO  = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        VERD_STACK      = 3'd0,
        VERD_QUEUE      = 3'd1,
        VERD_PRIO       = 3'd2,
        VERD_NOT_SURE   = 3'd3,
        VERD_IMPOSSIBLE = 3'd4
    } t_verdict;

    // Control from the top level into the sorted cell chain
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_prio_ctl;

    // Status back from the sorted cell chain
    typedef struct packed {
        logic empty;
        logic full;
    } t_prio_stat;

    // Verdict from the three candidate flags
    function automatic t_verdict verdict_of(input logic [2:0] f);
        t_verdict v;
        unique case (f)
            3'b001:  v = VERD_STACK;
            3'b010:  v = VERD_QUEUE;
            3'b100:  v = VERD_PRIO;
            3'b000:  v = VERD_IMPOSSIBLE;
            default: v = VERD_NOT_SURE;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/lfpoc_prio_chain.sv]
// Sorted cell chain holding the priority candidate, largest value in cell 0.
module lfpoc_prio_chain
    import lfpoc_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_prio_ctl             i_ctl,
    input  logic [VALUE_BITS-1:0] i_value,
    output t_prio_stat            o_stat,
    output logic [VALUE_BITS-1:0] o_max
);

    logic [VALUE_BITS-1:0] r_cell [STORE_DEPTH];
    logic [VALUE_BITS-1:0] n_cell [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] r_valid;
    logic [STORE_DEPTH-1:0] n_valid;
    // cell keeps its value on insert: valid and not smaller than the new value
    logic [STORE_DEPTH-1:0] keep;

    assign o_stat.empty = !r_valid[0];
    assign o_stat.full  = r_valid[STORE_DEPTH-1];
    assign o_max        = r_cell[0];

    genvar gi;
    generate
        for (gi = 0; gi < STORE_DEPTH; gi++) begin : g_cell
            logic                  prev_valid;
            logic                  prev_keep;
            logic [VALUE_BITS-1:0] prev_cell;
            logic                  next_valid;
            logic [VALUE_BITS-1:0] next_cell;

            assign keep[gi] = r_valid[gi] && (r_cell[gi] >= i_value);

            // neighbor above; cell 0 takes the new value when it does not keep
            if (gi == 0) begin : g_first
                assign prev_valid = 1'b1;
                assign prev_keep  = 1'b0;
                assign prev_cell  = i_value;
            end else begin : g_above
                assign prev_valid = r_valid[gi-1];
                assign prev_keep  = keep[gi-1];
                assign prev_cell  = r_cell[gi-1];
            end

            // neighbor below; the last cell empties on a pop
            if (gi == STORE_DEPTH-1) begin : g_last
                assign next_valid = 1'b0;
                assign next_cell  = r_cell[gi];
            end else begin : g_below
                assign next_valid = r_valid[gi+1];
                assign next_cell  = r_cell[gi+1];
            end

            // per-cell next value: hold, clear, insert, shift down or shift up
            always_comb begin
                n_cell[gi]  = r_cell[gi];
                n_valid[gi] = r_valid[gi];
                if (i_ctl.clear) begin
                    n_valid[gi] = 1'b0;
                end else if (i_ctl.push && !r_valid[STORE_DEPTH-1]) begin
                    n_valid[gi] = r_valid[gi] | prev_valid;
                    if (!keep[gi]) begin
                        n_cell[gi] = prev_keep ? i_value : prev_cell;
                    end
                end else if (i_ctl.pop) begin
                    n_valid[gi] = next_valid;
                    n_cell[gi]  = next_cell;
                end
            end

            // cell payload, no reset needed
            always_ff @(posedge i_clk) begin
                r_cell[gi] <= n_cell[gi];
            end
        end
    endgenerate

    // occupancy, thermometer coded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

[rtl/core/lifo_fifo_priority_order_checker_top.sv]
// Top level: stack and queue checkers, priority chain and result register.
// The result is registered and shown on the master side in the cycle after a request is taken.
// Throughput: one request per cycle while the master takes results; the sorted cell chain
// compare-and-shift and the stack / queue read with write bypass each finish in that cycle.
// Reset (synchronous, active low): counts and pointers go to zero, all three
// candidate flags are set, overflow is cleared; stores are not cleared.
module lifo_fifo_priority_order_checker_top
    import lfpoc_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH,
    parameter int VALUE_BITS  = DEF_VALUE_BITS,
    localparam int IN_BITS    = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [IN_BITS-1:0]  i_s_tdata,   // value, zero padded
    input  logic [CMD_BITS-1:0] i_s_tuser,   // command
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [RES_BITS-1:0] o_m_tdata    // verdict[2:0], stack, queue, prio, overflowed, pad
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(STORE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(STORE_DEPTH - 1);

    // ---------------- input decode ----------------
    logic                  r_run;
    logic                  acc;
    t_cmd                  cmd;
    logic [VALUE_BITS-1:0] val;
    logic                  is_push;
    logic                  is_pop;
    logic                  is_clear;

    assign acc      = i_s_tvalid && o_s_tready;
    assign cmd      = t_cmd'(i_s_tuser);
    assign val      = i_s_tdata[VALUE_BITS-1:0];
    assign is_push  = acc && (cmd == CMD_PUSH);
    assign is_pop   = acc && (cmd == CMD_POP);
    assign is_clear = acc && (cmd == CMD_CLEAR);

    // ---------------- state ----------------
    logic [CW-1:0] r_lcnt,  n_lcnt;
    logic [CW-1:0] r_qcnt,  n_qcnt;
    logic [AW-1:0] r_qhead, n_qhead;
    logic [AW-1:0] r_qtail, n_qtail;
    logic [2:0]    r_flags, n_flags;
    logic          r_ovf,   n_ovf;

    logic [VALUE_BITS-1:0] r_lmem [STORE_DEPTH];
    logic [VALUE_BITS-1:0] r_qmem [STORE_DEPTH];
    logic [VALUE_BITS-1:0] r_ltop;
    logic [VALUE_BITS-1:0] r_qfront;

    logic          l_we,  q_we;
    logic [AW-1:0] l_wa,  l_ra;
    logic [CW-1:0] l_ra_full;

    t_prio_ctl             p_ctl;
    t_prio_stat            p_stat;
    logic [VALUE_BITS-1:0] p_max;

    logic                  r_ovalid;
    logic [RES_BITS-1:0]   r_res;
    logic [RES_BITS-1:0]   n_res;

    assign o_s_tready = r_run && (!r_ovalid || i_m_tready);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_res;

    // ---------------- next-state logic ----------------
    always_comb begin
        n_lcnt  = r_lcnt;
        n_qcnt  = r_qcnt;
        n_qhead = r_qhead;
        n_qtail = r_qtail;
        n_flags = r_flags;
        n_ovf   = r_ovf;
        l_we    = 1'b0;
        q_we    = 1'b0;
        p_ctl   = '0;

        if (is_clear) begin
            n_lcnt      = '0;
            n_qcnt      = '0;
            n_qhead     = '0;
            n_qtail     = '0;
            n_flags     = 3'b111;
            p_ctl.clear = 1'b1;
        end else if (is_push) begin
            // stack
            if (r_lcnt != FULL_CNT) begin
                l_we   = 1'b1;
                n_lcnt = r_lcnt + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
            // queue
            if (r_qcnt != FULL_CNT) begin
                q_we    = 1'b1;
                n_qcnt  = r_qcnt + 1'b1;
                n_qtail = (r_qtail == LAST_IDX) ? '0 : r_qtail + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
            // priority
            if (p_stat.full) begin
                n_ovf = 1'b1;
            end
            p_ctl.push = 1'b1;
        end else if (is_pop) begin
            // stack: compare against top
            if (r_flags[FLAG_STACK]) begin
                if (r_lcnt == '0 || r_ltop != val) begin
                    n_flags[FLAG_STACK] = 1'b0;
                end else begin
                    n_lcnt = r_lcnt - 1'b1;
                end
            end
            // queue: compare against front
            if (r_flags[FLAG_QUEUE]) begin
                if (r_qcnt == '0 || r_qfront != val) begin
                    n_flags[FLAG_QUEUE] = 1'b0;
                end else begin
                    n_qcnt  = r_qcnt - 1'b1;
                    n_qhead = (r_qhead == LAST_IDX) ? '0 : r_qhead + 1'b1;
                end
            end
            // priority: compare against maximum
            if (r_flags[FLAG_PRIO]) begin
                if (p_stat.empty || p_max != val) begin
                    n_flags[FLAG_PRIO] = 1'b0;
                end else begin
                    p_ctl.pop = 1'b1;
                end
            end
        end
    end

    // ---------------- stack memory, next top prefetched ----------------
    assign l_wa      = r_lcnt[AW-1:0];
    assign l_ra_full = n_lcnt - 1'b1;
    assign l_ra      = l_ra_full[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (l_we) begin
            r_lmem[l_wa] <= val;
        end
        r_ltop <= (l_we && l_wa == l_ra) ? val : r_lmem[l_ra];
    end

    // ---------------- queue memory, next front prefetched ----------------
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_qmem[r_qtail] <= val;
        end
        r_qfront <= (q_we && r_qtail == n_qhead) ? val : r_qmem[n_qhead];
    end

    // ---------------- priority candidate ----------------
    lfpoc_prio_chain #(
        .STORE_DEPTH (STORE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_prio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (p_ctl),
        .i_value (val),
        .o_stat  (p_stat),
        .o_max   (p_max)
    );

    // ---------------- result word ----------------
    assign n_res = {1'b0, n_ovf, n_flags[FLAG_PRIO], n_flags[FLAG_QUEUE],
                    n_flags[FLAG_STACK], verdict_of(n_flags)};

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_lcnt   <= '0;
            r_qcnt   <= '0;
            r_qhead  <= '0;
            r_qtail  <= '0;
            r_flags  <= 3'b111;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_run   <= 1'b1;
            r_lcnt  <= n_lcnt;
            r_qcnt  <= n_qcnt;
            r_qhead <= n_qhead;
            r_qtail <= n_qtail;
            r_flags <= n_flags;
            r_ovf   <= n_ovf;
            if (acc) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_res <= n_res;
        end
    end

    // ---------------- assertions ----------------
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag dropped without reset");

    a_flag_stays_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run && !r_flags[FLAG_STACK] && !is_clear) |=> !r_flags[FLAG_STACK])
        else $error("stack flag set again without clear");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lcnt <= FULL_CNT) && (r_qcnt <= FULL_CNT))
        else $error("stack or queue count beyond depth");

    a_verdict_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> ((r_res[2:0] == VERD_IMPOSSIBLE) == (r_res[5:3] == 3'b000)))
        else $error("verdict disagrees with candidate flags");

endmodule
